/* rtl/s2x_pkg.sv */
// Package for the Scale2x scanline upscaler: field widths, register and command codes,
// the result record and the 75 percent RGB565 dimming functions.
// Used by every module of the block; depends on nothing.
package s2x_pkg;

  localparam int unsigned MaxWidthDef     = 512;
  localparam int unsigned MaxHeightDef    = 1024;
  localparam int unsigned RstActiveWidth  = 256;
  localparam int unsigned RstActiveHeight = 192;
  localparam int unsigned MinActive       = 3;

  localparam int unsigned PixW       = 16;
  localparam int unsigned CenterXW   = 9;
  localparam int unsigned CenterYW   = 10;
  localparam int unsigned ActWidthW  = 10;
  localparam int unsigned ActHeightW = 11;
  localparam int unsigned CfgDataW   = 11;
  localparam int unsigned CfgAddrW   = 1;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutFieldsW = CenterXW + CenterYW + 4 * PixW;
  localparam int unsigned OutDataW   = 88;
  localparam int unsigned OutPadW    = OutDataW - OutFieldsW;

  localparam int unsigned ResDepth = 8;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  typedef enum logic [CfgAddrW-1:0] {
    RegActiveWidth  = 1'b0,
    RegActiveHeight = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CmdPixel = 1'b0,
    CmdDrain = 1'b1
  } cmd_e;

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    pix_t top_left;
    pix_t top_right;
    pix_t bottom_left;
    pix_t bottom_right;
  } quad_t;

  typedef struct packed {
    logic [CenterXW-1:0] center_x;
    logic [CenterYW-1:0] center_y;
    quad_t               quad;
    logic                last_of_run;
    logic                frame_done;
  } res_t;

  // floor(3*c/4) for a 5-bit and a 6-bit channel.
  function automatic logic [4:0] dim5(logic [4:0] c);
    logic [6:0] t;
    t = {2'b00, c} + {1'b0, c, 1'b0};
    return t[6:2];
  endfunction

  function automatic logic [5:0] dim6(logic [5:0] c);
    logic [7:0] t;
    t = {2'b00, c} + {1'b0, c, 1'b0};
    return t[7:2];
  endfunction

  function automatic pix_t dim_pix(pix_t p);
    return {dim5(p[15:11]), dim6(p[10:5]), dim5(p[4:0])};
  endfunction

endpackage

/* rtl/s2x_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Holds the two source lines of the upscaler; depends on s2x_pkg for defaults.
module s2x_ram #(
  parameter int unsigned Width = 2 * s2x_pkg::PixW,
  parameter int unsigned Depth = s2x_pkg::MaxWidthDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/s2x_kernel.sv */
// Scale2x expansion of one centre pixel into a 2x2 block, lower row dimmed.
// Depends on s2x_pkg for the pixel and block types and the dimming function.
module s2x_kernel (
  input  s2x_pkg::pix_t  b_i,
  input  s2x_pkg::pix_t  d_i,
  input  s2x_pkg::pix_t  e_i,
  input  s2x_pkg::pix_t  f_i,
  input  s2x_pkg::pix_t  h_i,
  output s2x_pkg::quad_t quad_o
);

  always_comb begin
    s2x_pkg::pix_t e0;
    s2x_pkg::pix_t e1;
    s2x_pkg::pix_t e2;
    s2x_pkg::pix_t e3;
    e0 = e_i;
    e1 = e_i;
    e2 = e_i;
    e3 = e_i;
    if ((b_i != h_i) && (d_i != f_i)) begin
      e0 = (d_i == b_i) ? d_i : e_i;
      e1 = (b_i == f_i) ? f_i : e_i;
      e2 = (d_i == h_i) ? d_i : e_i;
      e3 = (h_i == f_i) ? f_i : e_i;
    end
    quad_o.top_left     = e0;
    quad_o.top_right    = e1;
    quad_o.bottom_left  = s2x_pkg::dim_pix(e2);
    quad_o.bottom_right = s2x_pkg::dim_pix(e3);
  end

endmodule

/* rtl/s2x_rfifo.sv */
// Result queue of the upscaler: takes up to two results per cycle, gives one.
// Depends on s2x_pkg for the result record and the queue depth.
module s2x_rfifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push0_i,
  input  s2x_pkg::res_t                 data0_i,
  input  logic                          push1_i,
  input  s2x_pkg::res_t                 data1_i,
  input  logic                          pop_i,
  output s2x_pkg::res_t                 head_o,
  output logic [s2x_pkg::ResCntW-1:0]   count_o
);

  s2x_pkg::res_t                 slots_q [s2x_pkg::ResDepth];
  logic [s2x_pkg::ResPtrW-1:0]   wp_q, wp_d, rp_q, rp_d, wp_next;
  logic [s2x_pkg::ResCntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wp_next = wp_q + s2x_pkg::ResPtrW'(1);
    wp_d    = wp_q + s2x_pkg::ResPtrW'(push0_i) + s2x_pkg::ResPtrW'(push1_i);
    rp_d    = rp_q + s2x_pkg::ResPtrW'(pop_i);
    cnt_d   = cnt_q + s2x_pkg::ResCntW'(push0_i) + s2x_pkg::ResCntW'(push1_i)
              - s2x_pkg::ResCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      slots_q[wp_q] <= data0_i;
    end
    if (push1_i) begin
      slots_q[push0_i ? wp_next : wp_q] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = slots_q[rp_q];
  assign count_o = cnt_q;

endmodule

/* rtl/scale2x_scanline_upscaler_unit.sv */
// Top level of the Scale2x scanline upscaler: line buffer RAM, 3x3 window, counters.
// Depends on s2x_pkg, s2x_ram, s2x_kernel and s2x_rfifo.
//
//   channel  direction  tdata                                  tlast        tuser
//   s_axis   in         pixel                                  -            command
//   m_axis   out        center_x .. bottom_right (see port)    last_of_run  frame_done
//   cfg      in         cfg_wdata_i at index cfg_addr_i        -            -
//
// One request is taken per clock while s_axis_tready is high; it reads the line RAM on acceptance
// and its results enter the eight-entry result queue in the next cycle, then wait there for m_axis.
// The line RAM read port and the read-modify-write of one entry set the pace of requests.
// s_axis_tready falls only while the result queue cannot take two more results.
// Reset clears counters and the queue at once; the line RAM needs no clearing pass.
module scale2x_scanline_upscaler_unit #(
  parameter int unsigned MAX_WIDTH  = s2x_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = s2x_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [s2x_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [s2x_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel[15:0]
  input  logic [s2x_pkg::InDataW-1:0]   s_axis_tdata,
  // command[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // center_x[8:0], center_y[18:9], top_left[34:19], top_right[50:35],
  // bottom_left[66:51], bottom_right[82:67], zero[87:83]
  output logic [s2x_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  // frame_done[0]
  output logic                          m_axis_tuser
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LineW = 2 * s2x_pkg::PixW;
  localparam int unsigned RstW  = (s2x_pkg::RstActiveWidth > MAX_WIDTH) ?
                                  MAX_WIDTH : s2x_pkg::RstActiveWidth;
  localparam int unsigned RstH  = (s2x_pkg::RstActiveHeight > MAX_HEIGHT) ?
                                  MAX_HEIGHT : s2x_pkg::RstActiveHeight;

  typedef struct packed {
    logic                is_drain;
    logic                emit_a;
    logic                emit_b;
    logic                has_top;
    logic                has_left;
    logic                has_right;
    logic                col0;
    logic                first_drain;
    logic                done;
    logic [CW-1:0]       col;
    logic [CW-1:0]       x0;
    logic [RW-1:0]       y;
    s2x_pkg::pix_t       pix;
  } stage_t;

  function automatic logic [WW-1:0] clamp_w(logic [s2x_pkg::ActWidthW-1:0] v);
    if (32'(v) < s2x_pkg::MinActive) begin
      return WW'(s2x_pkg::MinActive);
    end else if (32'(v) > MAX_WIDTH) begin
      return WW'(MAX_WIDTH);
    end
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(logic [s2x_pkg::ActHeightW-1:0] v);
    if (32'(v) < s2x_pkg::MinActive) begin
      return HW'(s2x_pkg::MinActive);
    end else if (32'(v) > MAX_HEIGHT) begin
      return HW'(MAX_HEIGHT);
    end
    return HW'(v);
  endfunction

  logic [WW-1:0] eff_w_q;
  logic [HW-1:0] eff_h_q;
  logic [CW-1:0] col_q, col_d, dcol_q, dcol_d;
  logic [RW-1:0] row_q, row_d;
  logic          dpend_q, dpend_d;
  logic          bv_q;
  stage_t        bk_q, stg_d;

  logic          acc, is_drain_in, col_end, row_end, dcol_end;
  logic [CW-1:0] raddr;

  s2x_pkg::pix_t prv_mid_q, cur_top_q, cur_mid_q, cur_bot_q;
  s2x_pkg::pix_t head_new_q, head_old_q;
  s2x_pkg::pix_t dleft_q, dcen_new_q, dcen_old_q;

  logic [LineW-1:0] rd_line;
  s2x_pkg::pix_t    rd_old, rd_new;
  s2x_pkg::pix_t    b0, d0, e0, f0, h0, b1;
  s2x_pkg::quad_t   quad0, quad1;
  s2x_pkg::res_t    res0, res1, head;
  logic             push0, push1, pop;
  logic [s2x_pkg::ResCntW-1:0] res_cnt;

  // Request side: counters, line RAM read address and stage B payload.
  always_comb begin
    acc         = s_axis_tvalid && s_axis_tready;
    is_drain_in = (s_axis_tuser == s2x_pkg::CmdDrain);
    col_end     = (WW'(col_q) + WW'(1)) >= eff_w_q;
    row_end     = (HW'(row_q) + HW'(1)) >= eff_h_q;
    dcol_end    = (WW'(dcol_q) + WW'(1)) >= eff_w_q;
    raddr       = is_drain_in ? (dcol_q + CW'(1)) : col_q;

    stg_d             = '0;
    stg_d.is_drain    = is_drain_in;
    stg_d.col         = col_q;
    stg_d.pix         = s_axis_tdata;
    if (is_drain_in) begin
      stg_d.emit_a      = dpend_q;
      stg_d.x0          = dcol_q;
      stg_d.y           = RW'(eff_h_q - HW'(1));
      stg_d.has_top     = 1'b1;
      stg_d.has_left    = dcol_q != '0;
      stg_d.has_right   = !dcol_end;
      stg_d.first_drain = dcol_q == '0;
      stg_d.done        = dcol_end;
    end else begin
      stg_d.emit_a      = (row_q != '0) && (col_q != '0);
      stg_d.emit_b      = (row_q != '0) && (col_q != '0) && col_end;
      stg_d.x0          = col_q - CW'(1);
      stg_d.y           = row_q - RW'(1);
      stg_d.has_top     = row_q >= RW'(2);
      stg_d.has_left    = col_q >= CW'(2);
      stg_d.has_right   = 1'b1;
      stg_d.col0        = col_q == '0;
    end

    col_d   = col_q;
    row_d   = row_q;
    dcol_d  = dcol_q;
    dpend_d = dpend_q;
    if (cfg_we_i) begin
      col_d   = '0;
      row_d   = '0;
      dcol_d  = '0;
      dpend_d = 1'b0;
    end else if (acc) begin
      if (is_drain_in) begin
        if (dpend_q) begin
          if (dcol_end) begin
            dpend_d = 1'b0;
            dcol_d  = '0;
          end else begin
            dcol_d = dcol_q + CW'(1);
          end
        end
      end else begin
        dpend_d = 1'b0;
        dcol_d  = '0;
        if (col_end) begin
          col_d = '0;
          if (row_end) begin
            row_d   = '0;
            dpend_d = 1'b1;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= WW'(RstW);
      eff_h_q <= HW'(RstH);
      col_q   <= '0;
      row_q   <= '0;
      dcol_q  <= '0;
      dpend_q <= 1'b0;
      bv_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          s2x_pkg::RegActiveWidth: begin
            eff_w_q <= clamp_w(cfg_wdata_i[s2x_pkg::ActWidthW-1:0]);
          end
          s2x_pkg::RegActiveHeight: begin
            eff_h_q <= clamp_h(cfg_wdata_i);
          end
          default: begin
          end
        endcase
      end
      col_q   <= col_d;
      row_q   <= row_d;
      dcol_q  <= dcol_d;
      dpend_q <= dpend_d;
      bv_q    <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      bk_q <= stg_d;
    end
  end

  s2x_ram #(
    .Width(LineW),
    .Depth(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (bv_q && !bk_q.is_drain),
    .waddr_i(bk_q.col),
    .wdata_i({rd_new, bk_q.pix}),
    .raddr_i(raddr),
    .rdata_o(rd_line)
  );

  // Stage B: window, neighbour selection and results.
  always_comb begin
    rd_old = rd_line[LineW-1:s2x_pkg::PixW];
    rd_new = rd_line[s2x_pkg::PixW-1:0];
    if (bk_q.is_drain) begin
      e0 = bk_q.first_drain ? head_new_q : dcen_new_q;
      b0 = bk_q.first_drain ? head_old_q : dcen_old_q;
      d0 = bk_q.has_left ? dleft_q : e0;
      h0 = e0;
    end else begin
      e0 = cur_mid_q;
      b0 = bk_q.has_top ? cur_top_q : e0;
      d0 = bk_q.has_left ? prv_mid_q : e0;
      h0 = cur_bot_q;
    end
    f0 = bk_q.has_right ? rd_new : e0;
    b1 = bk_q.has_top ? rd_old : rd_new;
  end

  s2x_kernel u_kernel_a (
    .b_i   (b0),
    .d_i   (d0),
    .e_i   (e0),
    .f_i   (f0),
    .h_i   (h0),
    .quad_o(quad0)
  );

  s2x_kernel u_kernel_b (
    .b_i   (b1),
    .d_i   (cur_mid_q),
    .e_i   (rd_new),
    .f_i   (rd_new),
    .h_i   (bk_q.pix),
    .quad_o(quad1)
  );

  always_comb begin
    res0.center_x    = s2x_pkg::CenterXW'(bk_q.x0);
    res0.center_y    = s2x_pkg::CenterYW'(bk_q.y);
    res0.quad        = quad0;
    res0.last_of_run = !bk_q.emit_b;
    res0.frame_done  = bk_q.done;
    res1.center_x    = s2x_pkg::CenterXW'(bk_q.col);
    res1.center_y    = s2x_pkg::CenterYW'(bk_q.y);
    res1.quad        = quad1;
    res1.last_of_run = 1'b1;
    res1.frame_done  = 1'b0;
    push0            = bv_q && bk_q.emit_a;
    push1            = bv_q && bk_q.emit_b;
  end

  always_ff @(posedge clk_i) begin
    if (bv_q && !bk_q.is_drain) begin
      prv_mid_q <= cur_mid_q;
      cur_top_q <= rd_old;
      cur_mid_q <= rd_new;
      cur_bot_q <= bk_q.pix;
      if (bk_q.col0) begin
        head_new_q <= bk_q.pix;
        head_old_q <= rd_new;
      end
    end
    if (bv_q && bk_q.is_drain && bk_q.emit_a) begin
      dleft_q    <= e0;
      dcen_new_q <= rd_new;
      dcen_old_q <= rd_old;
    end
  end

  s2x_rfifo u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push0_i(push0),
    .data0_i(res0),
    .push1_i(push1),
    .data1_i(res1),
    .pop_i  (pop),
    .head_o (head),
    .count_o(res_cnt)
  );

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (res_cnt + s2x_pkg::ResCntW'(push0) + s2x_pkg::ResCntW'(push1))
                         <= s2x_pkg::ResCntW'(s2x_pkg::ResDepth - 2);
  assign m_axis_tvalid = res_cnt != '0;
  assign m_axis_tdata  = {{s2x_pkg::OutPadW{1'b0}},
                          head.quad.bottom_right, head.quad.bottom_left,
                          head.quad.top_right, head.quad.top_left,
                          head.center_y, head.center_x};
  assign m_axis_tlast  = head.last_of_run;
  assign m_axis_tuser  = head.frame_done;

endmodule

/* rtl/s2x_checker.sv */
// Port-level checks on the result stream of the upscaler, and their binding.
// Depends on s2x_pkg and on scale2x_scanline_upscaler_unit.
module s2x_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [s2x_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tuser
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The frame's final result always closes its run.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame_done without last_of_run");

  // Both results of a request are queued together, so the second follows at once.
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("second result of a request missing");

  // Once reset has been seen at an edge, no result is offered at the next one.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

endmodule

bind scale2x_scanline_upscaler_unit s2x_checker u_s2x_checker (.*);
